@@ rtl/srhc_pkg.sv @@
package srhc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_MIN_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_MAX_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_MIN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_MAX_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH       = 3'd6;

    // One divider lane per rectangle edge
    localparam int LANES = 4;

    // Per-item flags that travel beside the divider lanes
    typedef struct packed {
        logic             zok;
        logic [LANES-1:0] pz;
        logic [LANES-1:0] pn;
        logic [LANES-1:0] qn;
    } side_t;

endpackage

@@ rtl/srhc_div.sv @@
module srhc_div #(
    parameter int Q_W       = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [Q_W-1:0]                 q,
    input  logic signed [Q_W-1:0]                 p,
    output logic signed [FRAC_BITS+3-1:0]         t
);

    localparam int MAG_W = Q_W;
    localparam int R_W   = MAG_W + 1;
    localparam int RES_W = FRAC_BITS + 1;
    localparam int T_W   = FRAC_BITS + 3;
    localparam logic [RES_W-1:0] SAT_VAL = RES_W'((64'd1 << FRAC_BITS) + 64'd1);

    logic [MAG_W-1:0] aq_reg, ap_reg;
    logic             nega_reg;

    logic [MAG_W-1:0] rem_reg [0:FRAC_BITS];
    logic [RES_W-1:0] res_reg [0:FRAC_BITS];
    logic [MAG_W-1:0] dv_reg  [0:FRAC_BITS];
    logic             neg_reg [0:FRAC_BITS];
    logic             sat_reg [0:FRAC_BITS];

    logic signed [T_W-1:0] t_reg;

    logic [MAG_W-1:0] aq_next, ap_next;
    logic             ip;
    logic [RES_W-1:0] mag_fin;
    logic signed [T_W-1:0] t_next;

    // Take magnitudes and the quotient sign
    always_comb
    begin
        aq_next = q[Q_W-1] ? MAG_W'(-q) : MAG_W'(q);
        ap_next = p[Q_W-1] ? MAG_W'(-p) : MAG_W'(p);
        ip      = (aq_reg >= ap_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aq_reg   <= aq_next;
            ap_reg   <= ap_next;
            nega_reg <= q[Q_W-1] ^ p[Q_W-1];
        end
    end

    // Integer bit and early saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= ({1'b0, aq_reg} >= {ap_reg, 1'b0});
            rem_reg[0] <= ip ? (aq_reg - ap_reg) : aq_reg;
            res_reg[0] <= RES_W'(ip);
            dv_reg[0]  <= ap_reg;
            neg_reg[0] <= nega_reg;
        end
    end

    // One restoring step per stage
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_step
        logic [R_W-1:0] r2;
        logic           ge;
        always_comb
        begin
            r2 = {rem_reg[i], 1'b0};
            ge = (r2 >= {1'b0, dv_reg[i]});
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? MAG_W'(r2 - {1'b0, dv_reg[i]}) : MAG_W'(r2);
                res_reg[i+1] <= {res_reg[i][RES_W-2:0], ge};
                dv_reg[i+1]  <= dv_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                sat_reg[i+1] <= sat_reg[i];
            end
        end
    end

    // Saturate and apply the sign
    always_comb
    begin
        if (sat_reg[FRAC_BITS] || (res_reg[FRAC_BITS] > SAT_VAL))
            mag_fin = SAT_VAL;
        else
            mag_fin = res_reg[FRAC_BITS];
        t_next = neg_reg[FRAC_BITS] ? -signed'(T_W'(mag_fin)) : signed'(T_W'(mag_fin));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            t_reg <= t_next;
    end

    assign t = t_reg;

endmodule

@@ rtl/segment_rect_hole_clip_unit.sv @@
// Liang-Barsky hole cut: each segment is tested against the XY hole rectangle when the hole
// is enabled and both endpoint heights lie in [z_low, z_high), and the parts of [0,1] outside
// the clipped interval come out as up to two kept spans in unsigned fixed point (FRAC_BITS
// fraction bits, 2^FRAC_BITS is one). One segment is accepted per cycle; each result passes
// the edge registers, four restoring dividers giving one quotient bit per stage, a combine
// register and the output register. The whole pipeline halts while a result is held.
module segment_rect_hole_clip_unit #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, zero pad
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hole_cut, first_valid, first_from, first_to, second_valid, second_from,
    // second_to, zero pad
    output logic [((3+4*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [srhc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    localparam int C       = COORD_BITS;
    localparam int S_W     = FRAC_BITS + 1;
    localparam int OUT_RAW = 3 + 4*S_W;
    localparam int OUT_W   = ((OUT_RAW+7)/8)*8;
    localparam int Q_W     = C + 1;
    localparam int T_W     = FRAC_BITS + 3;
    localparam int LAT     = FRAC_BITS + 3;
    localparam int L       = srhc_pkg::LANES;
    localparam logic signed [T_W-1:0] ONE_T = T_W'(64'd1 << FRAC_BITS);

    // Configuration registers
    logic                hole_en_reg;
    logic signed [C-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg, zlo_reg, zhi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_en_reg <= 1'b0;
            minx_reg    <= '0;
            maxx_reg    <= '0;
            miny_reg    <= '0;
            maxy_reg    <= '0;
            zlo_reg     <= '0;
            zhi_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srhc_pkg::CFG_HOLE_ENABLED: hole_en_reg <= cfg_data[0];
                srhc_pkg::CFG_RECT_MIN_X:   minx_reg    <= cfg_data;
                srhc_pkg::CFG_RECT_MAX_X:   maxx_reg    <= cfg_data;
                srhc_pkg::CFG_RECT_MIN_Y:   miny_reg    <= cfg_data;
                srhc_pkg::CFG_RECT_MAX_Y:   maxy_reg    <= cfg_data;
                srhc_pkg::CFG_Z_LOW:        zlo_reg     <= cfg_data;
                srhc_pkg::CFG_Z_HIGH:       zhi_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves unless a held result blocks the output
    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: edge distances and directions
    logic signed [C-1:0]   x0, y0, z0, x1, y1, z1;
    logic signed [Q_W-1:0] dx, dy;
    logic signed [Q_W-1:0] q_next [0:L-1];
    logic signed [Q_W-1:0] p_next [0:L-1];
    logic                  zok_next;

    always_comb
    begin
        x0 = s_tdata[0*C +: C];
        y0 = s_tdata[1*C +: C];
        z0 = s_tdata[2*C +: C];
        x1 = s_tdata[3*C +: C];
        y1 = s_tdata[4*C +: C];
        z1 = s_tdata[5*C +: C];
        dx = Q_W'(x1) - Q_W'(x0);
        dy = Q_W'(y1) - Q_W'(y0);
        p_next[0] = -dx;
        q_next[0] = Q_W'(x0) - Q_W'(minx_reg);
        p_next[1] = dx;
        q_next[1] = Q_W'(maxx_reg) - Q_W'(x0);
        p_next[2] = -dy;
        q_next[2] = Q_W'(y0) - Q_W'(miny_reg);
        p_next[3] = dy;
        q_next[3] = Q_W'(maxy_reg) - Q_W'(y0);
        zok_next  = hole_en_reg && (z0 >= zlo_reg) && (z0 < zhi_reg)
                    && (z1 >= zlo_reg) && (z1 < zhi_reg);
    end

    logic signed [Q_W-1:0] q1_reg [0:L-1];
    logic signed [Q_W-1:0] p1_reg [0:L-1];
    logic                  zok1_reg;
    logic                  v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < L; k++)
            begin
                q1_reg[k] <= q_next[k];
                p1_reg[k] <= p_next[k];
            end
            zok1_reg <= zok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    // Divider lanes, one per rectangle edge
    logic signed [T_W-1:0] t_lane [0:L-1];

    for (genvar k = 0; k < L; k++)
    begin : g_lane
        srhc_div #(
            .Q_W       (Q_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .q   (q1_reg[k]),
            .p   (p1_reg[k]),
            .t   (t_lane[k])
        );
    end

    // Flags and valid bits that ride beside the dividers
    srhc_pkg::side_t side_next;
    srhc_pkg::side_t side_reg [0:LAT-1];
    logic [LAT-1:0]  vd_reg;

    always_comb
    begin
        side_next.zok = zok1_reg;
        for (int k = 0; k < L; k++)
        begin
            side_next.pz[k] = (p1_reg[k] == '0);
            side_next.pn[k] = p1_reg[k][Q_W-1];
            side_next.qn[k] = q1_reg[k][Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[LAT-2:0], v1_reg};
    end

    // Combine: entering maximum, leaving minimum, parallel miss
    srhc_pkg::side_t       sd;
    logic signed [T_W-1:0] t0_next, t1_next;
    logic                  miss_next;

    always_comb
    begin
        sd        = side_reg[LAT-1];
        t0_next   = '0;
        t1_next   = ONE_T;
        miss_next = 1'b0;
        for (int k = 0; k < L; k++)
        begin
            if (sd.pz[k])
            begin
                if (sd.qn[k])
                    miss_next = 1'b1;
            end
            else if (sd.pn[k])
            begin
                if (t_lane[k] > t0_next)
                    t0_next = t_lane[k];
            end
            else
            begin
                if (t_lane[k] < t1_next)
                    t1_next = t_lane[k];
            end
        end
    end

    logic signed [T_W-1:0] t0c_reg, t1c_reg;
    logic                  missc_reg, zokc_reg, vc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0c_reg   <= t0_next;
            t1c_reg   <= t1_next;
            missc_reg <= miss_next;
            zokc_reg  <= sd.zok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= vd_reg[LAT-1];
    end

    // Span selection and packing
    logic           clip, a_ok, b_ok;
    logic           fv, sv;
    logic [S_W-1:0] ff, ft, sf, st;
    logic [OUT_W-1:0] out_next, m_tdata_reg;

    always_comb
    begin
        clip = zokc_reg && !missc_reg && (t0c_reg < t1c_reg);
        a_ok = (t0c_reg > 0);
        b_ok = (t1c_reg < ONE_T);
        fv = 1'b0;
        ff = '0;
        ft = '0;
        sv = 1'b0;
        sf = '0;
        st = '0;
        if (!clip)
        begin
            fv = 1'b1;
            ft = S_W'(ONE_T);
        end
        else if (a_ok)
        begin
            fv = 1'b1;
            ft = S_W'(t0c_reg);
            if (b_ok)
            begin
                sv = 1'b1;
                sf = S_W'(t1c_reg);
                st = S_W'(ONE_T);
            end
        end
        else if (b_ok)
        begin
            fv = 1'b1;
            ff = S_W'(t1c_reg);
            ft = S_W'(ONE_T);
        end
        out_next = OUT_W'({st, sf, sv, ft, ff, fv, clip});
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
            m_tdata_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= vc_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result without a cut keeps the whole segment as its first span
    a_nocut_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[1] && !m_tdata[2+2*S_W]))
        else $error("uncut result lacks the full span");

    // The second span never appears without the first
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2+2*S_W]) |-> m_tdata[1])
        else $error("second span without first");

    // A held result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result changed");

    // Accept whenever the output side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output space");

endmodule
